// File: src/software_timer_table_defines.svh
// Assertion macros used by the timer table control head
`ifndef SOFTWARE_TIMER_TABLE_DEFINES_SVH
`define SOFTWARE_TIMER_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define STT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("timer table assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset
`define STT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("timer table assertion failed");

`endif

// File: src/stt_pkg.sv
// Types and constants of the software timer table
`timescale 1ns / 1ps
package stt_pkg;

  localparam int NUM_SLOTS   = 8;
  localparam int MAX_RESULTS = 8;
  localparam int IDX_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam int CLIENT_W = 8;
  localparam int DELAY_W  = 31;
  localparam int TIME_W   = 32;
  localparam int STEP_W   = 10;

  localparam logic [STEP_W-1:0] TICK_STEP_RESET = STEP_W'(5);

  localparam logic REQ_TICK     = 1'b0;
  localparam logic REQ_REGISTER = 1'b1;

  localparam logic STATUS_PING = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic                busy;
    logic [CLIENT_W-1:0] client;
    logic [TIME_W-1:0]   period;
    logic [TIME_W-1:0]   due;
  } slot_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } ctrl_state_e;

endpackage

// File: src/stt_req_if.sv
// Request channel: tick or timer registration
`timescale 1ns / 1ps
interface stt_req_if;
  import stt_pkg::*;

  logic                valid;
  logic                ready;
  logic                req_type;
  logic [CLIENT_W-1:0] client_id;
  logic [DELAY_W-1:0]  delay_ms;
  logic                repeat_req;

  modport source (output valid, req_type, client_id, delay_ms, repeat_req, input ready);
  modport sink   (input valid, req_type, client_id, delay_ms, repeat_req, output ready);
endinterface

// File: src/stt_res_if.sv
// Result channel: pings and table-full errors
`timescale 1ns / 1ps
interface stt_res_if;
  import stt_pkg::*;

  logic                valid;
  logic                ready;
  logic [CLIENT_W-1:0] dest_client;
  logic [TIME_W-1:0]   due_time;
  logic                status;
  logic                last;

  modport source (output valid, dest_client, due_time, status, last, input ready);
  modport sink   (input valid, dest_client, due_time, status, last, output ready);
endinterface

// File: src/stt_cell.sv
// One timer slot of the rotating slot ring
`timescale 1ns / 1ps
module stt_cell
  import stt_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  shift_en_i,
  input  slot_t slot_i,
  output slot_t slot_o
);

  logic                busy_q;
  logic [CLIENT_W-1:0] client_q;
  logic [TIME_W-1:0]   period_q;
  logic [TIME_W-1:0]   due_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (shift_en_i) begin
      busy_q <= slot_i.busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      client_q <= slot_i.client;
      period_q <= slot_i.period;
      due_q    <= slot_i.due;
    end
  end

  assign slot_o = '{busy: busy_q, client: client_q, period: period_q, due: due_q};

endmodule

// File: src/stt_ctrl.sv
// Head of the slot ring: clock, slot update, result staging and output register
`timescale 1ns / 1ps
`include "software_timer_table_defines.svh"
module stt_ctrl
  import stt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [STEP_W-1:0] cfg_wdata_i,
  stt_req_if.sink           req_i,
  stt_res_if.source         res_o,
  input  slot_t             head_i,
  output slot_t             ret_o,
  output logic              shift_en_o
);

  ctrl_state_e state_q, state_d;

  logic [STEP_W-1:0]   step_q;
  logic [TIME_W-1:0]   clock_q;
  logic                is_tick_q;
  logic [CLIENT_W-1:0] client_q;
  logic [DELAY_W-1:0]  delay_q;
  logic                rep_q;
  logic [IDX_W-1:0]    idx_q;
  logic                found_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                held_vld_q;
  logic [CLIENT_W-1:0] held_client_q;
  logic [TIME_W-1:0]   held_due_q;

  logic                out_vld_q;
  logic [CLIENT_W-1:0] out_client_q;
  logic [TIME_W-1:0]   out_due_q;
  logic                out_status_q;
  logic                out_last_q;

  logic req_xfer, out_free, head_due, walk_stall, walk_end;
  logic emit_mid, emit_last, emit_err;

  assign req_xfer = req_i.valid && req_i.ready;
  assign out_free = !out_vld_q || res_o.ready;
  assign head_due = head_i.busy && (clock_q >= head_i.due)
                    && (cnt_q < CNT_W'(MAX_RESULTS));
  assign walk_stall = is_tick_q && head_due && held_vld_q && !out_free;
  assign walk_end = (idx_q == IDX_W'(NUM_SLOTS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_xfer) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (shift_en_o && walk_end) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (is_tick_q) begin
          if (!held_vld_q || out_free) state_d = ST_IDLE;
        end else begin
          if (found_q || out_free) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_i.ready = 1'b0;
    shift_en_o  = 1'b0;
    emit_mid    = 1'b0;
    emit_last   = 1'b0;
    emit_err    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
      end
      ST_WALK: begin
        shift_en_o = !walk_stall;
        emit_mid   = is_tick_q && head_due && held_vld_q && out_free;
      end
      ST_FLUSH: begin
        emit_last = is_tick_q && held_vld_q && out_free;
        emit_err  = !is_tick_q && !found_q && out_free;
      end
      default: ;
    endcase
  end

  // slot written back into the tail of the ring
  always_comb begin
    ret_o = head_i;
    if (!is_tick_q) begin
      if (!found_q && !head_i.busy) begin
        ret_o.busy   = 1'b1;
        ret_o.client = client_q;
        ret_o.period = rep_q ? {1'b0, delay_q} : '0;
        ret_o.due    = clock_q + {1'b0, delay_q};
      end
    end else if (head_due) begin
      if (head_i.period != '0) begin
        ret_o.due = head_i.due + head_i.period;
      end else begin
        ret_o.busy = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      step_q     <= TICK_STEP_RESET;
      clock_q    <= '0;
      is_tick_q  <= 1'b0;
      idx_q      <= '0;
      found_q    <= 1'b0;
      cnt_q      <= '0;
      held_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) step_q <= cfg_wdata_i;
      if (req_xfer) begin
        is_tick_q  <= (req_i.req_type == REQ_TICK);
        idx_q      <= '0;
        found_q    <= 1'b0;
        cnt_q      <= '0;
        held_vld_q <= 1'b0;
        if (req_i.req_type == REQ_TICK) clock_q <= clock_q + TIME_W'(step_q);
      end else if (shift_en_o) begin
        idx_q <= idx_q + IDX_W'(1);
        if (!is_tick_q && !head_i.busy) found_q <= 1'b1;
        if (is_tick_q && head_due) begin
          held_vld_q <= 1'b1;
          cnt_q      <= cnt_q + CNT_W'(1);
        end
      end else if (emit_last) begin
        held_vld_q <= 1'b0;
      end
      out_vld_q <= emit_mid || emit_last || emit_err || (out_vld_q && !res_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      client_q <= req_i.client_id;
      delay_q  <= req_i.delay_ms;
      rep_q    <= req_i.repeat_req;
    end
    if (shift_en_o && is_tick_q && head_due) begin
      held_client_q <= head_i.client;
      held_due_q    <= head_i.due;
    end
    if (emit_mid || emit_last) begin
      out_client_q <= held_client_q;
      out_due_q    <= held_due_q;
      out_status_q <= STATUS_PING;
      out_last_q   <= emit_last;
    end else if (emit_err) begin
      out_client_q <= client_q;
      out_due_q    <= '0;
      out_status_q <= STATUS_FULL;
      out_last_q   <= 1'b1;
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.dest_client = out_client_q;
  assign res_o.due_time    = out_due_q;
  assign res_o.status      = out_status_q;
  assign res_o.last        = out_last_q;

  `STT_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(MAX_RESULTS))
  `STT_ASSERT_NOW(a_reg_no_held, !is_tick_q && state_q != ST_IDLE, !held_vld_q)
  `STT_ASSERT_NOW(a_no_shift_out_of_walk, state_q != ST_WALK, !shift_en_o)
  `STT_ASSERT_NEXT(a_tick_adv, req_xfer && req_i.req_type == REQ_TICK,
                   clock_q == $past(clock_q) + TIME_W'($past(step_q)))

endmodule

// File: src/software_timer_table.sv
// Top level of the software timer table: control head plus a ring of slot cells
//
//  channel  | dir | transfer when       | payload
//  ---------+-----+---------------------+---------------------------------------
//  req_i    | in  | valid && ready      | req_type, client_id, delay_ms, repeat_req
//  res_o    | out | valid && ready      | dest_client, due_time, status, last
//  cfg      | in  | cfg_we_i            | cfg_wdata_i = tick_step_ms
//
// Each request passes through accept, one ring shift per slot through the control head,
// and a flush step for the final result; the slot ring thus rotates once per request.
// A new request is taken only in idle, once the flush of the last one is done.
// A ping found while the output register and staging register are both full
// stalls the ring until res_o takes a transfer.
// Reset zeroes the clock and all busy bits and loads the step register with 5.
`timescale 1ns / 1ps
module software_timer_table
  import stt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [STEP_W-1:0] cfg_wdata_i,
  stt_req_if.sink           req_i,
  stt_res_if.source         res_o
);

  slot_t cell_q [NUM_SLOTS];
  slot_t ret;
  logic  shift_en;

  stt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .res_o       (res_o),
    .head_i      (cell_q[0]),
    .ret_o       (ret),
    .shift_en_o  (shift_en)
  );

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    slot_t nxt;
    if (k == NUM_SLOTS - 1) begin : g_tail
      assign nxt = ret;
    end else begin : g_mid
      assign nxt = cell_q[k+1];
    end
    stt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_en_i (shift_en),
      .slot_i     (nxt),
      .slot_o     (cell_q[k])
    );
  end

endmodule

// File: sim/tb_software_timer_table.sv
// Testbench for the software timer table: directed script, then random phases checked by a predictor
`timescale 1ns / 1ps
module tb_software_timer_table;
  import stt_pkg::*;

  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 44;
  localparam int SETTLE_CYCLES  = 2 * NUM_SLOTS + 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PERIODIC_CAP   = 3;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_ONE
  } row_check_e;

  typedef struct packed {
    logic                req_type;
    logic [CLIENT_W-1:0] client_id;
    logic [DELAY_W-1:0]  delay_ms;
    logic                repeat_req;
  } timer_req_t;

  typedef struct packed {
    logic [CLIENT_W-1:0] dest_client;
    logic [TIME_W-1:0]   due_time;
    logic                status;
    logic                last;
  } expiry_t;

  typedef struct packed {
    logic                req_type;
    logic [CLIENT_W-1:0] client_id;
    logic [DELAY_W-1:0]  delay_ms;
    logic                repeat_req;
    row_check_e          check;
    logic [CLIENT_W-1:0] want_client;
    logic [TIME_W-1:0]   want_due;
    logic                want_status;
  } script_row_t;

  localparam int SCRIPT_LEN = 20;
  localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};

  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{REQ_TICK,     8'h00, 31'd0,     1'b0, CHK_NONE,  8'h00, 32'd0, STATUS_PING},
    '{REQ_REGISTER, 8'h00, 31'd0,     1'b1, CHK_NONE,  8'h00, 32'd0, STATUS_PING},
    '{REQ_TICK,     8'h00, 31'd0,     1'b0, CHK_ONE,   8'h00, 32'd5, STATUS_PING},
    '{REQ_REGISTER, 8'hFF, DELAY_MAX, 1'b1, CHK_NONE,  8'h00, 32'd0, STATUS_PING},
    '{REQ_REGISTER, 8'h11, 31'd0,     1'b0, CHK_NONE,  8'h00, 32'd0, STATUS_PING},
    '{REQ_REGISTER, 8'h22, 31'd5,     1'b1, CHK_NONE,  8'h00, 32'd0, STATUS_PING},
    '{REQ_REGISTER, 8'h33, 31'd12,    1'b0, CHK_NONE,  8'h00, 32'd0, STATUS_PING},
    '{REQ_REGISTER, 8'h44, 31'd3,     1'b0, CHK_NONE,  8'h00, 32'd0, STATUS_PING},
    '{REQ_REGISTER, 8'h55, 31'd20,    1'b0, CHK_NONE,  8'h00, 32'd0, STATUS_PING},
    '{REQ_REGISTER, 8'h66, 31'd7,     1'b0, CHK_NONE,  8'h00, 32'd0, STATUS_PING},
    '{REQ_REGISTER, 8'h77, 31'd1,     1'b0, CHK_NONE,  8'h00, 32'd0, STATUS_PING},
    '{REQ_REGISTER, 8'hAA, 31'd4,     1'b1, CHK_ONE,   8'hAA, 32'd0, STATUS_FULL},
    '{REQ_REGISTER, 8'h5A, DELAY_MAX, 1'b0, CHK_ONE,   8'h5A, 32'd0, STATUS_FULL},
    '{REQ_TICK,     8'h00, 31'd0,     1'b0, CHK_MODEL, 8'h00, 32'd0, STATUS_PING},
    '{REQ_TICK,     8'hFF, DELAY_MAX, 1'b1, CHK_MODEL, 8'h00, 32'd0, STATUS_PING},
    '{REQ_TICK,     8'h00, 31'd0,     1'b0, CHK_MODEL, 8'h00, 32'd0, STATUS_PING},
    '{REQ_TICK,     8'h00, 31'd0,     1'b0, CHK_MODEL, 8'h00, 32'd0, STATUS_PING},
    '{REQ_TICK,     8'h00, 31'd0,     1'b0, CHK_MODEL, 8'h00, 32'd0, STATUS_PING},
    '{REQ_TICK,     8'h00, 31'd0,     1'b0, CHK_MODEL, 8'h00, 32'd0, STATUS_PING},
    '{REQ_TICK,     8'h00, 31'd0,     1'b0, CHK_MODEL, 8'h00, 32'd0, STATUS_PING}
  };

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [STEP_W-1:0] cfg_wdata_i;

  stt_req_if req_if ();
  stt_res_if res_if ();

  software_timer_table DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  // predictor state
  logic [STEP_W-1:0] step_ms;
  logic [TIME_W-1:0] now_ms;
  slot_t             slots [NUM_SLOTS];
  expiry_t           fresh_pings [$];
  expiry_t           due_pings [$];

  int  fault_count;
  int  idle_cycles;
  int  big_left;
  bit  calm;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void advance_table(input timer_req_t rq);
    int      free_idx;
    int      n;
    int      i;
    expiry_t p;
    fresh_pings.delete();
    if (rq.req_type == REQ_REGISTER) begin
      free_idx = -1;
      for (i = NUM_SLOTS - 1; i >= 0; i--) begin
        if (!slots[i].busy) free_idx = i;
      end
      if (free_idx < 0) begin
        p.dest_client = rq.client_id;
        p.due_time    = '0;
        p.status      = STATUS_FULL;
        p.last        = 1'b1;
        fresh_pings.push_back(p);
      end else begin
        slots[free_idx].busy   = 1'b1;
        slots[free_idx].client = rq.client_id;
        slots[free_idx].due    = now_ms + TIME_W'(rq.delay_ms);
        slots[free_idx].period = rq.repeat_req ? TIME_W'(rq.delay_ms) : '0;
      end
    end else begin
      now_ms = now_ms + TIME_W'(step_ms);
      n = 0;
      for (i = 0; i < NUM_SLOTS; i++) begin
        if (n < MAX_RESULTS && slots[i].busy && now_ms >= slots[i].due) begin
          p.dest_client = slots[i].client;
          p.due_time    = slots[i].due;
          p.status      = STATUS_PING;
          p.last        = 1'b0;
          fresh_pings.push_back(p);
          n++;
          if (slots[i].period != '0) slots[i].due = slots[i].due + slots[i].period;
          else slots[i].busy = 1'b0;
        end
      end
      if (n > 0) begin
        p = fresh_pings[n-1];
        p.last = 1'b1;
        fresh_pings[n-1] = p;
      end
    end
  endfunction

  function automatic timer_req_t random_request();
    timer_req_t rq;
    int         reach;
    int         periodic;
    int         i;
    rq.req_type   = ($urandom_range(0, 99) < 55) ? REQ_TICK : REQ_REGISTER;
    rq.client_id  = CLIENT_W'($urandom_range(0, 255));
    rq.repeat_req = 1'($urandom_range(0, 1));
    reach = (step_ms == '0) ? 4 : 6 * int'(step_ms);
    rq.delay_ms = DELAY_W'($urandom_range(0, reach));
    if (rq.req_type == REQ_REGISTER) begin
      if (big_left > 0 && $urandom_range(0, 19) == 0) begin
        rq.delay_ms = DELAY_W'($urandom);
        big_left--;
      end
      // periodic timers never free their slot, so keep only a few alive
      periodic = 0;
      for (i = 0; i < NUM_SLOTS; i++) begin
        if (slots[i].busy && slots[i].period != '0) periodic++;
      end
      if (rq.repeat_req && periodic >= PERIODIC_CAP) rq.delay_ms = '0;
    end
    return rq;
  endfunction

  // returns at the edge where the request transfer happens
  task automatic push_request(input timer_req_t rq);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= rq.req_type;
    req_if.client_id  <= rq.client_id;
    req_if.delay_ms   <= rq.delay_ms;
    req_if.repeat_req <= rq.repeat_req;
    do @(posedge clk_i); while (!req_if.ready);
    advance_table(rq);
  endtask

  task automatic drain_pings();
    req_if.valid <= 1'b0;
    while (due_pings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_step(input logic [STEP_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    step_ms = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic flag_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fault_count++;
    end
  endtask

  // result sink with random back-pressure
  initial begin
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      res_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      if (pick_gap() > 0) begin
        res_if.ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    expiry_t e;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (due_pings.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual client %0h due %0h status %0b",
                 $time, res_if.dest_client, res_if.due_time, res_if.status);
        fault_count++;
      end else begin
        e = due_pings.pop_front();
        flag_field("dest_client", 32'(e.dest_client), 32'(res_if.dest_client));
        flag_field("due_time", e.due_time, res_if.due_time);
        flag_field("status", 32'(e.status), 32'(res_if.status));
        flag_field("last", 32'(e.last), 32'(res_if.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int               k;
    int               ph;
    timer_req_t       rq;
    expiry_t          typed;
    logic [STEP_W-1:0] steps [PHASES];

    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    req_if.valid      = 1'b0;
    req_if.req_type   = REQ_TICK;
    req_if.client_id  = '0;
    req_if.delay_ms   = '0;
    req_if.repeat_req = 1'b0;
    fault_count       = 0;
    idle_cycles       = 0;
    big_left          = 1;
    calm              = 1'b0;

    step_ms = TICK_STEP_RESET;
    now_ms  = '0;
    for (k = 0; k < NUM_SLOTS; k++) slots[k] = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < SCRIPT_LEN; k++) begin
      rq = '{SCRIPT[k].req_type, SCRIPT[k].client_id, SCRIPT[k].delay_ms,
             SCRIPT[k].repeat_req};
      push_request(rq);
      case (SCRIPT[k].check)
        CHK_MODEL: begin
          foreach (fresh_pings[j]) due_pings.push_back(fresh_pings[j]);
        end
        CHK_ONE: begin
          typed = '{SCRIPT[k].want_client, SCRIPT[k].want_due, SCRIPT[k].want_status, 1'b1};
          due_pings.push_back(typed);
        end
        default: begin
        end
      endcase
    end

    steps[0] = STEP_W'(1);
    steps[1] = STEP_W'(1000);
    steps[2] = '0;
    steps[3] = {STEP_W{1'b1}};
    steps[4] = STEP_W'($urandom_range(2, 999));
    steps[5] = STEP_W'($urandom_range(1, 1023));

    for (ph = 0; ph < PHASES; ph++) begin
      drain_pings();
      write_step(steps[ph]);
      calm = (ph % 3 == 2);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        push_request(random_request());
        foreach (fresh_pings[j]) due_pings.push_back(fresh_pings[j]);
      end
    end

    drain_pings();
    if (fault_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
